### sv/swpb_pkg.sv
`timescale 1ns / 1ps

package swpb_pkg;

  localparam int DEF_WINDOW_SLOTS = 10;
  localparam logic [3:0] THR_RESET = 4'd6;

  typedef enum logic [2:0] {
    CMD_MOVE   = 3'd0,
    CMD_RECV   = 3'd1,
    CMD_SELECT = 3'd2,
    CMD_READ   = 3'd3,
    CMD_START  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_PICK  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_EXEC,
    ST_SCAN_INIT,
    ST_SCAN_DN,
    ST_SCAN_UP,
    ST_DECIDE,
    ST_OUT
  } state_t;

endpackage

### sv/swpb_if.sv
`timescale 1ns / 1ps

interface swpb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] row;
  logic [15:0] total_count;
  logic [7:0]  entry_type;
  logic [31:0] entry_word;
  logic        title_nonempty;
  logic [7:0]  pick_mode;

  modport source (
    output valid, cmd, row, total_count, entry_type, entry_word, title_nonempty, pick_mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, row, total_count, entry_type, entry_word, title_nonempty, pick_mode,
    output ready
  );
endinterface

interface swpb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] out_row;
  logic [7:0]  out_mode;
  logic [7:0]  out_type;
  logic [31:0] out_word;
  logic        out_filled;

  modport source (
    output valid, result_kind, out_row, out_mode, out_type, out_word, out_filled,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_row, out_mode, out_type, out_word, out_filled,
    output ready
  );
endinterface

interface swpb_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] refill_threshold;

  modport source (output valid, refill_threshold, input ready);
  modport sink (input valid, refill_threshold, output ready);
endinterface

### sv/sliding_window_prefetch_buffer_unit.sv
`timescale 1ns / 1ps

// Sliding-window prefetch buffer. A ring of WINDOW_SLOTS slots caches list
// entries within WINDOW_SLOTS/2 rows of a centre row; every command yields
// exactly one result transaction. The block takes one command at a time: a
// select, a read or a reply that releases a latched pick passes through the
// accept, offset, execute and output steps before the next acceptance. A
// command that runs the refill scan adds a scan set-up step, then tests slots
// with the shared slot probe below and above the centre (at most
// WINDOW_SLOTS/2+1 each side), then takes a decision step. A finished result
// waits in the output register while the next command is accepted. The
// threshold register is always ready and takes effect at the next refill
// decision.
module sliding_window_prefetch_buffer_unit #(
  parameter int WINDOW_SLOTS = swpb_pkg::DEF_WINDOW_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  swpb_cfg_if.sink    cfg_chan,
  swpb_in_if.sink     in_chan,
  swpb_out_if.source  out_chan
);

  localparam int HALF = WINDOW_SLOTS / 2;
  localparam int IW   = $clog2(WINDOW_SLOTS);
  localparam int CW   = $clog2(WINDOW_SLOTS + 1);
  localparam int KW   = $clog2(HALF + 1);
  localparam int SW   = IW + 2;
  localparam int CMPW = (CW > 4) ? CW : 4;

  localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW_SLOTS - 1);
  localparam logic [KW-1:0] K_LAST   = KW'(HALF);
  localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW_SLOTS);
  localparam logic [CW-1:0] CNT_ALL  = CW'(HALF + 1);
  localparam logic signed [16:0] D_HALF = 17'(HALF);

  swpb_pkg::state_t state_r, state_nxt;

  logic [3:0]          thr_r;
  swpb_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [15:0]         row_r, row_nxt;
  logic [15:0]         tot_r, tot_nxt;
  logic [7:0]          etype_r, etype_nxt;
  logic [31:0]         eword_r, eword_nxt;
  logic                title_r, title_nxt;
  logic [7:0]          mode_r, mode_nxt;
  logic signed [16:0]  d_r, d_nxt;

  logic [15:0]         center_r, center_nxt;
  logic [IW-1:0]       ring_r, ring_nxt;
  logic [15:0]         len_r, len_nxt;
  logic                await_r, await_nxt;
  logic                pick_r, pick_nxt;
  logic [15:0]         prow_r, prow_nxt;
  logic [7:0]          pmode_r, pmode_nxt;

  logic [KW-1:0]       k_r, k_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [16:0]         pos_r, pos_nxt;
  logic [CW-1:0]       down_r, down_nxt;
  logic [CW-1:0]       up_r, up_nxt;

  swpb_pkg::kind_t     res_kind_r, res_kind_nxt;
  logic [15:0]         res_row_r, res_row_nxt;
  logic [7:0]          res_mode_r, res_mode_nxt;
  logic [7:0]          res_type_r, res_type_nxt;
  logic [31:0]         res_word_r, res_word_nxt;
  logic                res_filled_r, res_filled_nxt;

  logic                out_valid_r, out_valid_nxt;
  swpb_pkg::kind_t     out_kind_r, out_kind_nxt;
  logic [15:0]         out_row_r, out_row_nxt;
  logic [7:0]          out_mode_r, out_mode_nxt;
  logic [7:0]          out_type_r, out_type_nxt;
  logic [31:0]         out_word_r, out_word_nxt;
  logic                out_filled_r, out_filled_nxt;

  logic [WINDOW_SLOTS-1:0] slot_valid_r;
  logic [WINDOW_SLOTS-1:0] slot_filled_r;
  logic [7:0]              slot_type_r [WINDOW_SLOTS];
  logic [31:0]             slot_word_r [WINDOW_SLOTS];

  logic                clr_all, clr_one, wr_en;
  logic [IW-1:0]       clr_idx;

  logic                in_win;
  logic [SW-1:0]       t_sum, t_adj;
  logic [IW-1:0]       slot_idx;
  logic [IW:0]         clr_up_t, clr_dn_t;
  logic [IW-1:0]       ring_inc, ring_dec, idx_inc, idx_dec;

  // offset-to-slot mapping and ring arithmetic
  always_comb begin
    in_win   = (d_r <= D_HALF) && (d_r >= -D_HALF);
    t_sum    = SW'({2'b00, ring_r}) + d_r[SW-1:0];
    if (t_sum[SW-1]) begin
      t_adj = t_sum + SW'(WINDOW_SLOTS);
    end else if (t_sum >= SW'(WINDOW_SLOTS)) begin
      t_adj = t_sum - SW'(WINDOW_SLOTS);
    end else begin
      t_adj = t_sum;
    end
    slot_idx = t_adj[IW-1:0];

    ring_inc = (ring_r == IDX_LAST) ? '0 : ring_r + 1'b1;
    ring_dec = (ring_r == '0) ? IDX_LAST : ring_r - 1'b1;
    idx_inc  = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
    idx_dec  = (idx_r == '0) ? IDX_LAST : idx_r - 1'b1;

    clr_up_t = {1'b0, ring_r} + (IW+1)'(WINDOW_SLOTS + 1 - HALF);
    if (clr_up_t >= (IW+1)'(WINDOW_SLOTS)) begin
      clr_up_t = clr_up_t - (IW+1)'(WINDOW_SLOTS);
    end
    clr_dn_t = {1'b0, ring_r} + (IW+1)'(HALF - 1);
    if (clr_dn_t >= (IW+1)'(WINDOW_SLOTS)) begin
      clr_dn_t = clr_dn_t - (IW+1)'(WINDOW_SLOTS);
    end
  end

  assign in_chan.ready  = (state_r == swpb_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    row_nxt        = row_r;
    tot_nxt        = tot_r;
    etype_nxt      = etype_r;
    eword_nxt      = eword_r;
    title_nxt      = title_r;
    mode_nxt       = mode_r;
    d_nxt          = d_r;
    center_nxt     = center_r;
    ring_nxt       = ring_r;
    len_nxt        = len_r;
    await_nxt      = await_r;
    pick_nxt       = pick_r;
    prow_nxt       = prow_r;
    pmode_nxt      = pmode_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    down_nxt       = down_r;
    up_nxt         = up_r;
    res_kind_nxt   = res_kind_r;
    res_row_nxt    = res_row_r;
    res_mode_nxt   = res_mode_r;
    res_type_nxt   = res_type_r;
    res_word_nxt   = res_word_r;
    res_filled_nxt = res_filled_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_kind_nxt   = out_kind_r;
    out_row_nxt    = out_row_r;
    out_mode_nxt   = out_mode_r;
    out_type_nxt   = out_type_r;
    out_word_nxt   = out_word_r;
    out_filled_nxt = out_filled_r;
    clr_all        = 1'b0;
    clr_one        = 1'b0;
    clr_idx        = '0;
    wr_en          = 1'b0;

    case (state_r)
      swpb_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt   = swpb_pkg::cmd_t'(in_chan.cmd);
          row_nxt   = in_chan.row;
          tot_nxt   = in_chan.total_count;
          etype_nxt = in_chan.entry_type;
          eword_nxt = in_chan.entry_word;
          title_nxt = in_chan.title_nonempty;
          mode_nxt  = in_chan.pick_mode;
          state_nxt = swpb_pkg::ST_DIFF;
        end
      end

      swpb_pkg::ST_DIFF: begin
        d_nxt          = $signed({1'b0, row_r}) - $signed({1'b0, center_r});
        res_kind_nxt   = swpb_pkg::KIND_NONE;
        res_row_nxt    = '0;
        res_mode_nxt   = '0;
        res_type_nxt   = '0;
        res_word_nxt   = '0;
        res_filled_nxt = 1'b0;
        state_nxt      = swpb_pkg::ST_EXEC;
      end

      swpb_pkg::ST_EXEC: begin
        state_nxt = swpb_pkg::ST_OUT;
        case (cmd_r)
          swpb_pkg::CMD_MOVE: begin
            center_nxt = row_r;
            if (d_r == 17'sd1) begin
              ring_nxt = ring_inc;
              clr_one  = 1'b1;
              clr_idx  = clr_up_t[IW-1:0];
            end else if (d_r == -17'sd1) begin
              ring_nxt = ring_dec;
              clr_one  = 1'b1;
              clr_idx  = clr_dn_t[IW-1:0];
            end else if (d_r != 17'sd0) begin
              clr_all = 1'b1;
            end
            state_nxt = swpb_pkg::ST_SCAN_INIT;
          end
          swpb_pkg::CMD_RECV: begin
            len_nxt   = tot_r;
            wr_en     = in_win;
            await_nxt = 1'b0;
            if (pick_r) begin
              pick_nxt     = 1'b0;
              res_kind_nxt = swpb_pkg::KIND_PICK;
              res_row_nxt  = prow_r;
              res_mode_nxt = pmode_r;
            end else begin
              state_nxt = swpb_pkg::ST_SCAN_INIT;
            end
          end
          swpb_pkg::CMD_SELECT: begin
            if (await_r) begin
              pick_nxt  = 1'b1;
              prow_nxt  = row_r;
              pmode_nxt = mode_r;
            end else begin
              res_kind_nxt = swpb_pkg::KIND_PICK;
              res_row_nxt  = row_r;
              res_mode_nxt = mode_r;
            end
          end
          swpb_pkg::CMD_READ: begin
            res_kind_nxt = swpb_pkg::KIND_READ;
            res_row_nxt  = row_r;
            if (in_win && slot_valid_r[slot_idx]) begin
              res_type_nxt   = slot_type_r[slot_idx];
              res_word_nxt   = slot_word_r[slot_idx];
              res_filled_nxt = slot_filled_r[slot_idx];
            end
          end
          swpb_pkg::CMD_START: begin
            clr_all    = 1'b1;
            center_nxt = '0;
            ring_nxt   = '0;
            await_nxt  = 1'b0;
            pick_nxt   = 1'b0;
            prow_nxt   = '0;
            pmode_nxt  = '0;
            state_nxt  = swpb_pkg::ST_SCAN_INIT;
          end
          default: begin
          end
        endcase
      end

      swpb_pkg::ST_SCAN_INIT: begin
        k_nxt   = '0;
        idx_nxt = ring_r;
        pos_nxt = {1'b0, center_r};
        if (await_r) begin
          state_nxt = swpb_pkg::ST_OUT;
        end else begin
          state_nxt = swpb_pkg::ST_SCAN_DN;
        end
      end

      swpb_pkg::ST_SCAN_DN: begin
        if (pos_r >= {1'b0, len_r}) begin
          down_nxt = CNT_FULL;
        end else if (!slot_filled_r[idx_r]) begin
          down_nxt = CW'(k_r);
        end else if (k_r == K_LAST) begin
          down_nxt = CNT_ALL;
        end
        if ((pos_r >= {1'b0, len_r}) || !slot_filled_r[idx_r] || (k_r == K_LAST)) begin
          k_nxt     = '0;
          idx_nxt   = ring_r;
          pos_nxt   = {1'b0, center_r};
          state_nxt = swpb_pkg::ST_SCAN_UP;
        end else begin
          k_nxt   = k_r + 1'b1;
          idx_nxt = idx_inc;
          pos_nxt = pos_r + 1'b1;
        end
      end

      swpb_pkg::ST_SCAN_UP: begin
        if (pos_r[16]) begin
          up_nxt = CNT_FULL;
        end else if (!slot_filled_r[idx_r]) begin
          up_nxt = CW'(k_r);
        end else if (k_r == K_LAST) begin
          up_nxt = CNT_ALL;
        end
        if (pos_r[16] || !slot_filled_r[idx_r] || (k_r == K_LAST)) begin
          state_nxt = swpb_pkg::ST_DECIDE;
        end else begin
          k_nxt   = k_r + 1'b1;
          idx_nxt = idx_dec;
          pos_nxt = pos_r - 1'b1;
        end
      end

      swpb_pkg::ST_DECIDE: begin
        if ((CMPW'(down_r) < CMPW'(thr_r)) && (down_r <= up_r)) begin
          res_kind_nxt = swpb_pkg::KIND_FETCH;
          res_row_nxt  = center_r + 16'(down_r);
          await_nxt    = 1'b1;
        end else if (CMPW'(up_r) < CMPW'(thr_r)) begin
          res_kind_nxt = swpb_pkg::KIND_FETCH;
          res_row_nxt  = center_r - 16'(up_r);
          await_nxt    = 1'b1;
        end
        state_nxt = swpb_pkg::ST_OUT;
      end

      swpb_pkg::ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_row_nxt    = res_row_r;
          out_mode_nxt   = res_mode_r;
          out_type_nxt   = res_type_r;
          out_word_nxt   = res_word_r;
          out_filled_nxt = res_filled_r;
          state_nxt      = swpb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = swpb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swpb_pkg::ST_IDLE;
      thr_r       <= swpb_pkg::THR_RESET;
      center_r    <= '0;
      ring_r      <= '0;
      len_r       <= '0;
      await_r     <= 1'b0;
      pick_r      <= 1'b0;
      prow_r      <= '0;
      pmode_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_chan.valid) begin
        thr_r <= cfg_chan.refill_threshold;
      end
      center_r    <= center_nxt;
      ring_r      <= ring_nxt;
      len_r       <= len_nxt;
      await_r     <= await_nxt;
      pick_r      <= pick_nxt;
      prow_r      <= prow_nxt;
      pmode_r     <= pmode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    row_r        <= row_nxt;
    tot_r        <= tot_nxt;
    etype_r      <= etype_nxt;
    eword_r      <= eword_nxt;
    title_r      <= title_nxt;
    mode_r       <= mode_nxt;
    d_r          <= d_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    down_r       <= down_nxt;
    up_r         <= up_nxt;
    res_kind_r   <= res_kind_nxt;
    res_row_r    <= res_row_nxt;
    res_mode_r   <= res_mode_nxt;
    res_type_r   <= res_type_nxt;
    res_word_r   <= res_word_nxt;
    res_filled_r <= res_filled_nxt;
    out_kind_r   <= out_kind_nxt;
    out_row_r    <= out_row_nxt;
    out_mode_r   <= out_mode_nxt;
    out_type_r   <= out_type_nxt;
    out_word_r   <= out_word_nxt;
    out_filled_r <= out_filled_nxt;
  end

  // slot flags: a slot that is not valid reads as empty with zero contents
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      slot_valid_r  <= '0;
      slot_filled_r <= '0;
    end else begin
      if (clr_one) begin
        slot_valid_r[clr_idx]  <= 1'b0;
        slot_filled_r[clr_idx] <= 1'b0;
      end
      if (wr_en) begin
        slot_valid_r[slot_idx]  <= 1'b1;
        slot_filled_r[slot_idx] <= title_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_type_r[slot_idx] <= etype_r;
      slot_word_r[slot_idx] <= eword_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.out_row     = out_row_r;
  assign out_chan.out_mode    = out_mode_r;
  assign out_chan.out_type    = out_type_r;
  assign out_chan.out_word    = out_word_r;
  assign out_chan.out_filled  = out_filled_r;

endmodule

### sv/swpb_checker.sv
`timescale 1ns / 1ps

module swpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [15:0] out_row,
  input logic [7:0]  out_mode,
  input logic [7:0]  out_type,
  input logic [31:0] out_word,
  input logic        out_filled
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(out_row)
      && $stable(out_mode) && $stable(out_type) && $stable(out_word) && $stable(out_filled))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while one is in progress");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind == swpb_pkg::KIND_NONE) |-> (out_row == 16'd0))
    else $error("empty result carries a row");

  a_slot_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind != swpb_pkg::KIND_READ)
      |-> (out_type == 8'd0) && (out_word == 32'd0) && !out_filled)
    else $error("slot contents on a non-read result");

  a_mode_only_on_pick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind != swpb_pkg::KIND_PICK) |-> (out_mode == 8'd0))
    else $error("mode on a non-pick result");

endmodule

bind sliding_window_prefetch_buffer_unit swpb_checker u_swpb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .result_kind (out_chan.result_kind),
  .out_row     (out_chan.out_row),
  .out_mode    (out_chan.out_mode),
  .out_type    (out_chan.out_type),
  .out_word    (out_chan.out_word),
  .out_filled  (out_chan.out_filled)
);
